// ===== design/arac_pkg.sv =====
`default_nettype none

package arac_pkg;

    localparam int ADDR_W          = 48;
    localparam int CNT_W           = 32;
    localparam int IDXF_W          = 6;
    localparam int DEFAULT_ENTRIES = 64;

    localparam logic [1:0] REQ_ACCESS = 2'd0;
    localparam logic [1:0] REQ_SET    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_READ   = 2'd3;

    localparam logic [1:0] KIND_STORE = 2'd1;
    localparam logic [1:0] KIND_LOAD  = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] address;
        logic [1:0]        access_kind;
        logic [IDXF_W-1:0] entry_index;
        logic [ADDR_W-1:0] region_limit;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [IDXF_W-1:0] hit_index;
        logic [CNT_W-1:0]  entry_read_count;
        logic [CNT_W-1:0]  entry_write_count;
        logic [CNT_W-1:0]  total_read_count;
        logic [CNT_W-1:0]  total_write_count;
    } t_res;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] limit;
        logic [CNT_W-1:0]  reads;
        logic [CNT_W-1:0]  writes;
    } t_row;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] reads;
        logic [CNT_W-1:0] writes;
    } t_match;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== design/arac_match.sv =====
`default_nettype none

module arac_match (
    input  arac_pkg::t_row                  i_row,
    input  logic [arac_pkg::ADDR_W-1:0]     i_address,
    input  logic [1:0]                      i_kind,
    output arac_pkg::t_match                o_res
);

    logic w_eq;
    logic w_ge;
    logic w_lt;

    always_comb begin
        w_eq = (i_row.base == i_address);
        w_ge = (i_row.base <= i_address);
        w_lt = (i_address < i_row.limit);

        o_res.hit    = i_row.valid && (w_eq || (w_ge && w_lt));
        o_res.reads  = (i_kind == arac_pkg::KIND_LOAD)
                       ? arac_pkg::sat_inc(i_row.reads) : i_row.reads;
        o_res.writes = (i_kind == arac_pkg::KIND_STORE)
                       ? arac_pkg::sat_inc(i_row.writes) : i_row.writes;
    end

endmodule

`default_nettype wire

// ===== design/address_region_access_counter.sv =====
`default_nettype none

// The region table sits in one memory with a single read port, and an access scans it one
// entry per cycle in index order through one shared compare unit, stopping at the first hit.
// An access passes through S_SCAN, then on a hit through S_UPD, which writes the updated counters
// back, and then S_DONE; a miss goes from S_SCAN to S_DONE. Set, remove and read requests pass
// through S_IDX, which reads the entry, and S_OP, then S_DONE, and go straight to S_DONE for an
// index beyond the table. A finished result waits in an output register, so the next request
// may start meanwhile; a request that finishes while that register still holds an unaccepted
// result waits until that result's transfer.
// After reset a clearing pass writes every table row once before the first input
// transfer is taken.
module address_region_access_counter #(
    parameter int ENTRIES = arac_pkg::DEFAULT_ENTRIES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  arac_pkg::t_req  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output arac_pkg::t_res  o_out_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_IDX   = 3'd4;
    localparam logic [2:0] S_OP    = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]                    r_state,     n_state;
    logic [IDX_W-1:0]              r_scan,      n_scan;
    logic [IDX_W-1:0]              r_chk_idx,   n_chk_idx;
    logic                          r_chk_vld,   n_chk_vld;
    arac_pkg::t_req                r_req,       n_req;
    arac_pkg::t_res                r_res,       n_res;
    logic [arac_pkg::CNT_W-1:0]    r_loads,     n_loads;
    logic [arac_pkg::CNT_W-1:0]    r_stores,    n_stores;
    logic                          r_out_valid, n_out_valid;
    arac_pkg::t_res                r_out_data,  n_out_data;

    arac_pkg::t_row                r_mem [ENTRIES];
    arac_pkg::t_row                r_rd_row;

    logic                          mem_we;
    logic [IDX_W-1:0]              mem_wa;
    arac_pkg::t_row                mem_wd;
    logic                          rd_en;
    logic [IDX_W-1:0]              rd_addr;

    logic                          in_fire;
    logic                          in_table;
    arac_pkg::t_match              m_res;

    arac_match u_match (
        .i_row     (r_rd_row),
        .i_address (r_req.address),
        .i_kind    (r_req.access_kind),
        .o_res     (m_res)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign in_fire     = i_in_valid && o_in_ready;
    assign in_table    = (32'(i_in_data.entry_index) < 32'(ENTRIES));

    always_comb begin
        n_state     = r_state;
        n_scan      = r_scan;
        n_chk_idx   = r_chk_idx;
        n_chk_vld   = r_chk_vld;
        n_req       = r_req;
        n_res       = r_res;
        n_loads     = r_loads;
        n_stores    = r_stores;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        mem_we      = 1'b0;
        mem_wa      = r_chk_idx;
        mem_wd      = r_rd_row;
        rd_en       = 1'b0;
        rd_addr     = r_scan;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_scan;
                mem_wd = '0;
                n_scan = r_scan + IDX_W'(1);
                if (r_scan == LAST_IDX) begin
                    n_scan  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_req     = i_in_data;
                    n_scan    = '0;
                    n_chk_idx = '0;
                    n_chk_vld = 1'b0;
                    n_res     = '0;
                    if (i_in_data.req_type == arac_pkg::REQ_ACCESS) begin
                        if (i_in_data.access_kind == arac_pkg::KIND_LOAD) begin
                            n_loads = arac_pkg::sat_inc(r_loads);
                        end else if (i_in_data.access_kind == arac_pkg::KIND_STORE) begin
                            n_stores = arac_pkg::sat_inc(r_stores);
                        end
                        n_state = S_SCAN;
                    end else begin
                        n_res.hit_index = i_in_data.entry_index;
                        n_state = in_table ? S_IDX : S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (r_chk_vld && m_res.hit) begin
                    n_state = S_UPD;
                end else if (r_chk_vld && (r_chk_idx == LAST_IDX)) begin
                    n_state = S_DONE;
                end else begin
                    rd_en     = 1'b1;
                    rd_addr   = r_scan;
                    n_scan    = r_scan + IDX_W'(1);
                    n_chk_idx = r_scan;
                    n_chk_vld = 1'b1;
                end
            end
            S_UPD: begin
                mem_we                  = 1'b1;
                mem_wa                  = r_chk_idx;
                mem_wd.reads            = m_res.reads;
                mem_wd.writes           = m_res.writes;
                n_res.hit               = 1'b1;
                n_res.hit_index         = arac_pkg::IDXF_W'(r_chk_idx);
                n_res.entry_read_count  = m_res.reads;
                n_res.entry_write_count = m_res.writes;
                n_state                 = S_DONE;
            end
            S_IDX: begin
                rd_en   = 1'b1;
                rd_addr = IDX_W'(r_req.entry_index);
                n_state = S_OP;
            end
            S_OP: begin
                mem_wa = IDX_W'(r_req.entry_index);
                unique case (r_req.req_type)
                    arac_pkg::REQ_SET: begin
                        mem_we       = 1'b1;
                        mem_wd.valid = 1'b1;
                        mem_wd.base  = r_req.address;
                        mem_wd.limit = r_req.region_limit;
                        mem_wd.reads  = '0;
                        mem_wd.writes = '0;
                        n_res.hit    = 1'b1;
                    end
                    arac_pkg::REQ_REMOVE: begin
                        mem_we                  = 1'b1;
                        mem_wd.valid            = 1'b0;
                        n_res.hit               = r_rd_row.valid;
                        n_res.entry_read_count  = r_rd_row.reads;
                        n_res.entry_write_count = r_rd_row.writes;
                    end
                    arac_pkg::REQ_READ: begin
                        n_res.hit               = r_rd_row.valid;
                        n_res.entry_read_count  = r_rd_row.reads;
                        n_res.entry_write_count = r_rd_row.writes;
                    end
                    default: begin
                        n_res.hit = 1'b0;
                    end
                endcase
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid                  = 1'b1;
                    n_out_data                   = r_res;
                    n_out_data.total_read_count  = r_loads;
                    n_out_data.total_write_count = r_stores;
                    n_state                      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_scan      <= '0;
            r_chk_vld   <= 1'b0;
            r_loads     <= '0;
            r_stores    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan      <= n_scan;
            r_chk_vld   <= n_chk_vld;
            r_loads     <= n_loads;
            r_stores    <= n_stores;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx  <= n_chk_idx;
        r_req      <= n_req;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_row <= r_mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_we_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_CLEAR || r_state == S_UPD || r_state == S_OP))
        else $error("Table written outside a clearing, update or request step.");

    a_upd_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state == S_UPD) |-> mem_wd.valid)
        else $error("Counter update written to an entry that is not valid.");

    a_totals_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> ($stable(r_loads) && $stable(r_stores)))
        else $error("Totals changed without an accepted access.");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("Result presented without completing a request.");
`endif

endmodule

`default_nettype wire
